[rtl/assert_macros.svh]
// Assertion macros for the filter RTL.
// No dependencies; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and reset.
`define ASSERT_AT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion on the module's clock and reset.
`define ASSERT_ALWAYS(name, prop, msg) \
   `ASSERT_AT(name, clock, reset, prop, msg)

`endif

[rtl/pcmlf_pkg.sv]
// Types and constants for the per-channel median and lowpass filter.
// No dependencies; used by the controller, the datapath and the top level.
package pcmlf_pkg;

   localparam int VALUE_W = 10;
   localparam int ACC_W = 18;
   localparam int SHIFT_W = 4;
   localparam int CHAN_W = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_MEDIAN_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWPASS_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWPASS_SHIFT = 2'd2;

   localparam logic [SHIFT_W-1:0] SHIFT_MIN = 4'd1;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX = 4'd8;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_LOAD,
      ST_SEARCH,
      ST_FILTER,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic median_enable;
      logic lowpass_enable;
      logic [SHIFT_W-1:0] lowpass_shift;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic prep;
      logic load;
      logic search;
      logic filter;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic drop;
      logic use_median;
      logic load_done;
      logic found;
      logic out_free;
   } status_type;

endpackage

[rtl/pcmlf_ctrl.sv]
// Sequencing state machine for the filter: accept, window load, rank search,
// lowpass and result hand-off. Depends on pcmlf_pkg.
module pcmlf_ctrl import pcmlf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PREP;
         end
         ST_PREP: begin
            if (status.drop) state_in = ST_FINISH;
            else if (status.use_median) state_in = ST_LOAD;
            else state_in = ST_FILTER;
         end
         ST_LOAD: begin
            if (status.load_done) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (status.found) state_in = ST_FILTER;
         end
         ST_FILTER: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.accept = req_valid;
         end
         ST_PREP:   cmd.prep = 1'b1;
         ST_LOAD:   cmd.load = 1'b1;
         ST_SEARCH: cmd.search = 1'b1;
         ST_FILTER: cmd.filter = 1'b1;
         ST_FINISH: cmd.emit = status.out_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[rtl/pcmlf_datapath.sv]
// Datapath: input capture, per-channel window memory and state, rank search,
// exponential lowpass and output register. Depends on pcmlf_pkg.
`include "assert_macros.svh"
module pcmlf_datapath import pcmlf_pkg::*; #(
   parameter int CHANNELS = 6,
   parameter int WINDOW = 23
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [CHAN_W-1:0]  req_channel,
   input  logic [VALUE_W-1:0] req_sample,
   input  logic               req_overrun,
   input  cfg_type            cfg,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [VALUE_W-1:0] rsp_filtered
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int W_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int N_W = $clog2(WINDOW + 1);
   localparam int DEPTH = CHANNELS * WINDOW;
   localparam int A_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // captured item
   logic [CH_W-1:0]    ch_ff;
   logic [VALUE_W-1:0] sample_ff;
   logic               drop_ff;

   // per-channel state
   logic [W_W-1:0]     pos_ff [CHANNELS];
   logic [N_W-1:0]     fill_ff [CHANNELS];
   logic [ACC_W-1:0]   acc_ff [CHANNELS];

   // window store
   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] mem_q_ff;

   // per-item median context
   logic [A_W-1:0]     base_ff;
   logic [N_W-1:0]     n_ff;
   logic [N_W-1:0]     rank_ff;
   logic [N_W-1:0]     load_cnt_ff;
   logic               rd_v_ff;
   logic [W_W-1:0]     rd_slot_ff;
   logic [VALUE_W-1:0] win_ff [WINDOW];

   // rank search pipeline
   logic [W_W-1:0]     cand_ff;
   logic               flag_v_ff;
   logic [WINDOW-1:0]  gt_ff;
   logic [WINDOW-1:0]  ge_ff;
   logic [VALUE_W-1:0] cand_val_ff;
   logic [VALUE_W-1:0] median_ff;

   logic [VALUE_W-1:0] result_ff;
   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_filtered_ff;

   logic [W_W-1:0]     pos_cur;
   logic [W_W-1:0]     pos_in;
   logic [N_W-1:0]     fill_cur;
   logic [N_W-1:0]     fill_in;
   logic [N_W:0]       rank_sum;
   logic [A_W-1:0]     base_in;
   logic [A_W-1:0]     wr_addr;
   logic [A_W-1:0]     rd_addr;
   logic               rd_en;
   logic               med_write;
   logic [VALUE_W-1:0] cand_val;
   logic [WINDOW-1:0]  gt_in;
   logic [WINDOW-1:0]  ge_in;
   logic [N_W-1:0]     above;
   logic [N_W-1:0]     at_or_above;
   logic               hit;
   logic [SHIFT_W-1:0] k_eff;
   logic [VALUE_W-1:0] x_sel;
   logic [ACC_W-1:0]   acc_cur;
   logic [ACC_W-1:0]   acc_in;
   logic [VALUE_W-1:0] lp_out;

   // ---- item capture ----
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ch_ff <= CH_W'(req_channel);
         sample_ff <= (req_sample == '0) ? VALUE_W'(1) : req_sample;
         drop_ff <= req_overrun || (int'(req_channel) >= CHANNELS);
      end
   end

   // ---- window bookkeeping ----
   always_comb begin
      pos_cur = pos_ff[ch_ff];
      fill_cur = fill_ff[ch_ff];
      pos_in = (pos_cur == W_W'(WINDOW - 1)) ? '0 : pos_cur + W_W'(1);
      fill_in = (fill_cur < N_W'(WINDOW)) ? fill_cur + N_W'(1) : fill_cur;
      rank_sum = {1'b0, fill_in} + (N_W + 1)'(2);
      base_in = A_W'(int'(ch_ff) * WINDOW);
      wr_addr = base_in + A_W'(pos_cur);
      med_write = cmd.prep && !drop_ff && cfg.median_enable;
      rd_en = cmd.load && (load_cnt_ff < n_ff);
      rd_addr = base_ff + A_W'(load_cnt_ff);
   end

   always_ff @(posedge clock) begin
      if (med_write) begin
         mem[wr_addr] <= sample_ff;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            pos_ff[c] <= '0;
            fill_ff[c] <= '0;
            acc_ff[c] <= '0;
         end
         rd_v_ff <= 1'b0;
         flag_v_ff <= 1'b0;
      end else begin
         if (med_write) begin
            pos_ff[ch_ff] <= pos_in;
            fill_ff[ch_ff] <= fill_in;
         end
         if (cmd.filter && cfg.lowpass_enable) begin
            acc_ff[ch_ff] <= acc_in;
         end
         rd_v_ff <= rd_en;
         flag_v_ff <= cmd.search;
      end
   end

   always_ff @(posedge clock) begin
      if (med_write) begin
         base_ff <= base_in;
         n_ff <= fill_in;
         rank_ff <= rank_sum[N_W:1];
         load_cnt_ff <= '0;
         cand_ff <= '0;
      end
      if (rd_en) begin
         rd_slot_ff <= load_cnt_ff[W_W-1:0];
         load_cnt_ff <= load_cnt_ff + N_W'(1);
      end
      if (rd_v_ff) begin
         win_ff[rd_slot_ff] <= mem_q_ff;
      end
      if (cmd.search) begin
         gt_ff <= gt_in;
         ge_ff <= ge_in;
         cand_val_ff <= cand_val;
         if ((N_W'(cand_ff) + N_W'(1)) < n_ff) begin
            cand_ff <= cand_ff + W_W'(1);
         end
         if (hit) begin
            median_ff <= cand_val_ff;
         end
      end
   end

   // ---- rank search: compare stage, then count stage ----
   always_comb begin
      cand_val = win_ff[cand_ff];
      for (int j = 0; j < WINDOW; j++) begin
         gt_in[j] = (N_W'(j) < n_ff) && (win_ff[j] > cand_val);
         ge_in[j] = (N_W'(j) < n_ff) && (win_ff[j] >= cand_val);
      end
   end

   always_comb begin
      above = '0;
      at_or_above = '0;
      for (int j = 0; j < WINDOW; j++) begin
         above = above + N_W'(gt_ff[j]);
         at_or_above = at_or_above + N_W'(ge_ff[j]);
      end
      hit = flag_v_ff && (above < rank_ff) && (rank_ff <= at_or_above);
   end

   // ---- lowpass ----
   always_comb begin
      if (cfg.lowpass_shift < SHIFT_MIN) k_eff = SHIFT_MIN;
      else if (cfg.lowpass_shift > SHIFT_MAX) k_eff = SHIFT_MAX;
      else k_eff = cfg.lowpass_shift;
      x_sel = cfg.median_enable ? median_ff : sample_ff;
      acc_cur = acc_ff[ch_ff];
      acc_in = acc_cur - (acc_cur >> k_eff) + ACC_W'(x_sel);
      lp_out = VALUE_W'(acc_in >> k_eff);
   end

   always_ff @(posedge clock) begin
      if (cmd.prep && drop_ff) begin
         result_ff <= '0;
      end else if (cmd.filter) begin
         result_ff <= cfg.lowpass_enable ? lp_out : x_sel;
      end
      if (cmd.emit) begin
         rsp_filtered_ff <= result_ff;
      end
   end

   // ---- output register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

   assign status.drop = drop_ff;
   assign status.use_median = cfg.median_enable;
   assign status.load_done = (load_cnt_ff == n_ff) && !rd_v_ff;
   assign status.found = hit;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   `ASSERT_ALWAYS(a_load_range, cmd.load |-> (n_ff != '0) && (rank_ff <= n_ff) && (int'(n_ff) <= WINDOW), "window count or rank out of range")
   `ASSERT_ALWAYS(a_cand_range, cmd.search |-> (N_W'(cand_ff) < n_ff), "search candidate beyond held samples")
   `ASSERT_ALWAYS(a_emit_free, cmd.emit |-> (!rsp_valid_ff || !rsp_stall), "result overwrites a pending item")

endmodule

[rtl/per_channel_median_lowpass_filter.sv]
// Per-channel running median (window WINDOW) and exponential lowpass filter.
// Paths from accept to rsp_valid: a short one for overrun or bad channel, one with the
// median bypassed, and one with the median on whose length grows with n (samples held,
// max WINDOW), set by the single-port window memory load and the one-candidate-per-cycle
// rank search. One item in flight; the next is taken while a result waits.
// Synchronous reset clears channel state and config (median and lowpass on, shift 6).
module per_channel_median_lowpass_filter import pcmlf_pkg::*; #(
   parameter int CHANNELS = 6,
   parameter int WINDOW = 23
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [CHAN_W-1:0]      req_channel,
   input  logic [VALUE_W-1:0]     req_sample,
   input  logic                   req_overrun,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VALUE_W-1:0]     rsp_filtered,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   cmd_type    cmd;
   status_type status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MEDIAN_ENABLE:  cfg_in.median_enable = csr_data[0];
            CSR_LOWPASS_ENABLE: cfg_in.lowpass_enable = csr_data[0];
            CSR_LOWPASS_SHIFT:  cfg_in.lowpass_shift = csr_data[SHIFT_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.median_enable <= 1'b1;
         cfg_ff.lowpass_enable <= 1'b1;
         cfg_ff.lowpass_shift <= SHIFT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pcmlf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pcmlf_datapath #(
      .CHANNELS (CHANNELS),
      .WINDOW   (WINDOW)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_channel  (req_channel),
      .req_sample   (req_sample),
      .req_overrun  (req_overrun),
      .cfg          (cfg_ff),
      .cmd          (cmd),
      .status       (status),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_filtered (rsp_filtered)
   );

endmodule
